FILE: rtl/pfa_index_permutation_top_macros.svh
// Assertion macros for the permutation generator top level.
`ifndef PFA_INDEX_PERMUTATION_TOP_MACROS_SVH
`define PFA_INDEX_PERMUTATION_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PFA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PFA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pfa_pkg.sv
package pfa_pkg;

    localparam int unsigned MAX_POINTS  = 4096;
    localparam int unsigned FACTOR_MAX  = 4096;

    localparam int unsigned MODE_W      = 2;
    localparam int unsigned FACTOR_W    = 13;
    localparam int unsigned STEP_W      = 12;
    localparam int unsigned BASE_W      = 24;
    localparam int unsigned STRIDE_W    = 13;
    localparam int unsigned ADDR_W      = 25;
    localparam int unsigned COUNT_W     = 12;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    localparam int unsigned MUL_A_W     = 2 * FACTOR_W;
    localparam int unsigned MUL_B_W     = FACTOR_W;
    localparam int unsigned MUL_P_W     = MUL_A_W + MUL_B_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_FWD2 = 2'd0,
        MODE_BWD2 = 2'd1,
        MODE_FWD3 = 2'd2,
        MODE_BWD3 = 2'd3
    } map_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAP_MODE       = 3'd0,
        REG_FACTOR_ONE     = 3'd1,
        REG_FACTOR_TWO     = 3'd2,
        REG_FACTOR_THREE   = 3'd3,
        REG_STEP_FIRST     = 3'd4,
        REG_STEP_SECOND    = 3'd5,
        REG_BASE_ADDRESS   = 3'd6,
        REG_ADDRESS_STRIDE = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        map_mode_t           map_mode;
        logic [FACTOR_W-1:0] factor_one;
        logic [FACTOR_W-1:0] factor_two;
        logic [FACTOR_W-1:0] factor_three;
        logic [STEP_W-1:0]   step_first;
        logic [STEP_W-1:0]   step_second;
        logic [BASE_W-1:0]   base_address;
        logic [STRIDE_W-1:0] address_stride;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_N12,
        ST_N123,
        ST_T1,
        ST_T2,
        ST_SUM,
        ST_SRC,
        ST_DST,
        ST_COMMIT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_N12,
        MUL_N123,
        MUL_T1,
        MUL_T2,
        MUL_SRC,
        MUL_DST
    } mul_op_t;

    typedef struct packed {
        logic    accept;
        mul_op_t op;
        logic    reduce;
        logic    sum;
        logic    commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

FILE: rtl/pfa_stream_if.sv
interface pfa_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface pfa_desc_if;
    logic                       valid;
    logic                       ready;
    logic [pfa_pkg::ADDR_W-1:0] source_address;
    logic [pfa_pkg::ADDR_W-1:0] dest_address;
    logic                       frame_last;
    logic                       config_error;

    modport source (output valid, output source_address, output dest_address,
                    output frame_last, output config_error, input ready);
    modport sink (input valid, input source_address, input dest_address,
                  input frame_last, input config_error, output ready);
endinterface

FILE: rtl/pfa_cfg_regs.sv
module pfa_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pfa_pkg::cfg_t                   cfg
);

    pfa_pkg::cfg_t cfg_reg;
    pfa_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (pfa_pkg::cfg_reg_t'(cfg_index))
                pfa_pkg::REG_MAP_MODE:
                    cfg_next.map_mode = pfa_pkg::map_mode_t'(cfg_data[pfa_pkg::MODE_W-1:0]);
                pfa_pkg::REG_FACTOR_ONE:
                    cfg_next.factor_one = cfg_data[pfa_pkg::FACTOR_W-1:0];
                pfa_pkg::REG_FACTOR_TWO:
                    cfg_next.factor_two = cfg_data[pfa_pkg::FACTOR_W-1:0];
                pfa_pkg::REG_FACTOR_THREE:
                    cfg_next.factor_three = cfg_data[pfa_pkg::FACTOR_W-1:0];
                pfa_pkg::REG_STEP_FIRST:
                    cfg_next.step_first = cfg_data[pfa_pkg::STEP_W-1:0];
                pfa_pkg::REG_STEP_SECOND:
                    cfg_next.step_second = cfg_data[pfa_pkg::STEP_W-1:0];
                pfa_pkg::REG_BASE_ADDRESS:
                    cfg_next.base_address = cfg_data[pfa_pkg::BASE_W-1:0];
                pfa_pkg::REG_ADDRESS_STRIDE:
                    cfg_next.address_stride = cfg_data[pfa_pkg::STRIDE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_mode       <= pfa_pkg::MODE_FWD2;
            cfg_reg.factor_one     <= pfa_pkg::FACTOR_W'(1);
            cfg_reg.factor_two     <= pfa_pkg::FACTOR_W'(1);
            cfg_reg.factor_three   <= pfa_pkg::FACTOR_W'(1);
            cfg_reg.step_first     <= '0;
            cfg_reg.step_second    <= '0;
            cfg_reg.base_address   <= '0;
            cfg_reg.address_stride <= pfa_pkg::STRIDE_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/pfa_ctrl.sv
module pfa_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pfa_pkg::status_t status,
    output pfa_pkg::cmd_t    cmd
);

    pfa_pkg::state_t state_reg;
    pfa_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfa_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = pfa_pkg::ST_N12;
                end
            pfa_pkg::ST_N12:    state_next = pfa_pkg::ST_N123;
            pfa_pkg::ST_N123:   state_next = pfa_pkg::ST_T1;
            pfa_pkg::ST_T1:     state_next = pfa_pkg::ST_T2;
            pfa_pkg::ST_T2:     state_next = pfa_pkg::ST_SUM;
            pfa_pkg::ST_SUM:    state_next = pfa_pkg::ST_SRC;
            pfa_pkg::ST_SRC:    state_next = pfa_pkg::ST_DST;
            pfa_pkg::ST_DST:    state_next = pfa_pkg::ST_COMMIT;
            pfa_pkg::ST_COMMIT:
                if (status.out_free)
                begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            default:            state_next = pfa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd = '{accept: 1'b0, op: pfa_pkg::MUL_NONE, reduce: 1'b0, sum: 1'b0, commit: 1'b0};
        unique case (state_reg)
            pfa_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            pfa_pkg::ST_N12:
            begin
                cmd.op     = pfa_pkg::MUL_N12;
                cmd.reduce = 1'b1;
            end
            pfa_pkg::ST_N123:   cmd.op = pfa_pkg::MUL_N123;
            pfa_pkg::ST_T1:     cmd.op = pfa_pkg::MUL_T1;
            pfa_pkg::ST_T2:     cmd.op = pfa_pkg::MUL_T2;
            pfa_pkg::ST_SUM:    cmd.sum = 1'b1;
            pfa_pkg::ST_SRC:    cmd.op = pfa_pkg::MUL_SRC;
            pfa_pkg::ST_DST:    cmd.op = pfa_pkg::MUL_DST;
            pfa_pkg::ST_COMMIT: cmd.commit = status.out_free;
            default:            in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/pfa_datapath.sv
module pfa_datapath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  pfa_pkg::cfg_t              cfg,
    input  pfa_pkg::cmd_t              cmd,
    output pfa_pkg::status_t           status,
    input  logic                       in_restart,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [pfa_pkg::ADDR_W-1:0] out_source_address,
    output logic [pfa_pkg::ADDR_W-1:0] out_dest_address,
    output logic                       out_frame_last,
    output logic                       out_config_error
);

    localparam int unsigned FW = pfa_pkg::FACTOR_W;
    localparam int unsigned CW = pfa_pkg::COUNT_W;
    localparam int unsigned AW = pfa_pkg::ADDR_W;

    function automatic logic [FW-1:0] red_mod(input logic [FW-1:0] a, input logic [FW-1:0] m);
        return (a >= m) ? (a - m) : a;
    endfunction

    function automatic logic factor_ok(input logic [FW-1:0] f);
        return (f >= FW'(1)) && (f <= FW'(pfa_pkg::FACTOR_MAX));
    endfunction

    logic [CW-1:0] outer_reg, outer_next;
    logic [CW-1:0] middle_reg, middle_next;
    logic [CW-1:0] inner_reg, inner_next;
    logic [CW-1:0] acc1_reg, acc1_next;
    logic [CW-1:0] acc2_reg, acc2_next;
    logic [AW-1:0] seq_reg, seq_next;

    logic [pfa_pkg::MUL_A_W-1:0] n12_reg;
    logic                        ok_reg;
    logic [FW-1:0]               lo_reg, mid_reg, hi_reg;
    logic [AW-1:0]               t1_reg, t2_reg, idx_reg, src_reg, dst_reg;

    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] out_src_reg, out_dst_reg;
    logic          out_last_reg, out_err_reg;

    logic          three, backward;
    logic [FW-1:0] n1, n2, n3_eff, mod_a, mod_b;
    logic [FW-1:0] lim_outer, lim_mid, lim_inner;
    logic [FW-1:0] sum_o_a1, sum_m_a1, sum_m_a2, sum_o_a2;
    logic [FW-1:0] lo_next, mid_next, hi_next;
    logic [FW-1:0] acc1_red, acc2_red;
    logic [FW-1:0] inner_inc, middle_inc, outer_inc;
    logic          steps_ok, factors_ok, last_next;

    logic [pfa_pkg::MUL_A_W-1:0] mul_a;
    logic [pfa_pkg::MUL_B_W-1:0] mul_b;
    logic [pfa_pkg::MUL_P_W-1:0] prod;
    logic [AW-1:0]               src_idx, dst_idx, base_ext;

    assign three    = (cfg.map_mode == pfa_pkg::MODE_FWD3) || (cfg.map_mode == pfa_pkg::MODE_BWD3);
    assign backward = (cfg.map_mode == pfa_pkg::MODE_BWD2) || (cfg.map_mode == pfa_pkg::MODE_BWD3);
    assign n1       = cfg.factor_one;
    assign n2       = cfg.factor_two;
    assign n3_eff   = three ? cfg.factor_three : FW'(1);
    assign mod_a    = backward ? n2 : n1;
    assign mod_b    = (cfg.map_mode == pfa_pkg::MODE_FWD3) ? n2 : n3_eff;
    assign lim_mid  = three ? n2 : FW'(1);

    always_comb
    begin
        unique case (cfg.map_mode)
            pfa_pkg::MODE_FWD2:
            begin
                lim_outer = n1;
                lim_inner = n2;
            end
            pfa_pkg::MODE_BWD2:
            begin
                lim_outer = n2;
                lim_inner = n1;
            end
            pfa_pkg::MODE_FWD3:
            begin
                lim_outer = n1;
                lim_inner = n3_eff;
            end
            pfa_pkg::MODE_BWD3:
            begin
                lim_outer = n3_eff;
                lim_inner = n1;
            end
        endcase
    end

    assign factors_ok = factor_ok(n1) && factor_ok(n2) && factor_ok(n3_eff);
    assign steps_ok   = ({1'b0, cfg.step_first} < mod_a)
                        && (!three || ({1'b0, cfg.step_second} < mod_b));

    assign sum_o_a1 = {1'b0, outer_reg} + {1'b0, acc1_reg};
    assign sum_m_a1 = {1'b0, middle_reg} + {1'b0, acc1_reg};
    assign sum_m_a2 = {1'b0, middle_reg} + {1'b0, acc2_reg};
    assign sum_o_a2 = {1'b0, outer_reg} + {1'b0, acc2_reg};

    always_comb
    begin
        unique case (cfg.map_mode)
            pfa_pkg::MODE_FWD2:
            begin
                lo_next  = red_mod(sum_o_a1, n1);
                mid_next = {1'b0, inner_reg};
                hi_next  = '0;
            end
            pfa_pkg::MODE_BWD2:
            begin
                lo_next  = {1'b0, inner_reg};
                mid_next = red_mod(sum_o_a1, n2);
                hi_next  = '0;
            end
            pfa_pkg::MODE_FWD3:
            begin
                lo_next  = red_mod(sum_o_a1, n1);
                mid_next = red_mod(sum_m_a2, n2);
                hi_next  = {1'b0, inner_reg};
            end
            pfa_pkg::MODE_BWD3:
            begin
                lo_next  = {1'b0, inner_reg};
                mid_next = red_mod(sum_m_a1, n2);
                hi_next  = red_mod(sum_o_a2, n3_eff);
            end
        endcase
    end

    assign src_idx  = backward ? idx_reg : seq_reg;
    assign dst_idx  = backward ? seq_reg : idx_reg;
    assign base_ext = {1'b0, cfg.base_address};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            pfa_pkg::MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            pfa_pkg::MUL_N12:
            begin
                mul_a = pfa_pkg::MUL_A_W'(n1);
                mul_b = n2;
            end
            pfa_pkg::MUL_N123:
            begin
                mul_a = n12_reg;
                mul_b = n3_eff;
            end
            pfa_pkg::MUL_T1:
            begin
                mul_a = pfa_pkg::MUL_A_W'(n1);
                mul_b = mid_reg;
            end
            pfa_pkg::MUL_T2:
            begin
                mul_a = n12_reg;
                mul_b = hi_reg;
            end
            pfa_pkg::MUL_SRC:
            begin
                mul_a = pfa_pkg::MUL_A_W'(src_idx);
                mul_b = cfg.address_stride;
            end
            pfa_pkg::MUL_DST:
            begin
                mul_a = pfa_pkg::MUL_A_W'(dst_idx);
                mul_b = cfg.address_stride;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = pfa_pkg::MUL_P_W'(mul_a) * pfa_pkg::MUL_P_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.reduce)
        begin
            lo_reg  <= lo_next;
            mid_reg <= mid_next;
            hi_reg  <= hi_next;
        end
        unique case (cmd.op)
            pfa_pkg::MUL_N12:  n12_reg <= prod[pfa_pkg::MUL_A_W-1:0];
            pfa_pkg::MUL_N123: ok_reg  <= factors_ok && steps_ok
                                          && (prod <= pfa_pkg::MUL_P_W'(pfa_pkg::MAX_POINTS));
            pfa_pkg::MUL_T1:   t1_reg  <= prod[AW-1:0];
            pfa_pkg::MUL_T2:   t2_reg  <= prod[AW-1:0];
            pfa_pkg::MUL_SRC:  src_reg <= base_ext + prod[AW-1:0];
            pfa_pkg::MUL_DST:  dst_reg <= base_ext + prod[AW-1:0];
            default:           n12_reg <= n12_reg;
        endcase
        if (cmd.sum)
        begin
            idx_reg <= AW'(lo_reg) + t1_reg + t2_reg;
        end
    end

    assign acc1_red   = red_mod({1'b0, acc1_reg} + {1'b0, cfg.step_first}, mod_a);
    assign acc2_red   = red_mod({1'b0, acc2_reg} + {1'b0, cfg.step_second}, mod_b);
    assign inner_inc  = {1'b0, inner_reg} + FW'(1);
    assign middle_inc = {1'b0, middle_reg} + FW'(1);
    assign outer_inc  = {1'b0, outer_reg} + FW'(1);

    always_comb
    begin
        outer_next  = outer_reg;
        middle_next = middle_reg;
        inner_next  = inner_reg;
        acc1_next   = acc1_reg;
        acc2_next   = acc2_reg;
        seq_next    = seq_reg;
        last_next   = 1'b0;
        if ((cmd.accept && in_restart) || (cmd.commit && !ok_reg))
        begin
            outer_next  = '0;
            middle_next = '0;
            inner_next  = '0;
            acc1_next   = '0;
            acc2_next   = '0;
            seq_next    = '0;
        end
        else if (cmd.commit)
        begin
            acc1_next = acc1_red[CW-1:0];
            acc2_next = three ? acc2_red[CW-1:0] : '0;
            seq_next  = seq_reg + AW'(1);
            if (inner_inc >= lim_inner)
            begin
                inner_next = '0;
                if (cfg.map_mode == pfa_pkg::MODE_FWD3)
                begin
                    acc2_next = '0;
                end
                if (cfg.map_mode == pfa_pkg::MODE_BWD3)
                begin
                    acc1_next = '0;
                end
                if (middle_inc >= lim_mid)
                begin
                    middle_next = '0;
                    acc1_next   = '0;
                    acc2_next   = '0;
                    if (outer_inc >= lim_outer)
                    begin
                        outer_next = '0;
                        seq_next   = '0;
                        last_next  = 1'b1;
                    end
                    else
                    begin
                        outer_next = outer_inc[CW-1:0];
                    end
                end
                else
                begin
                    middle_next = middle_inc[CW-1:0];
                end
            end
            else
            begin
                inner_next = inner_inc[CW-1:0];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_src_reg  <= ok_reg ? src_reg : '0;
            out_dst_reg  <= ok_reg ? dst_reg : '0;
            out_last_reg <= ok_reg && last_next;
            out_err_reg  <= !ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_reg     <= '0;
            middle_reg    <= '0;
            inner_reg     <= '0;
            acc1_reg      <= '0;
            acc2_reg      <= '0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            outer_reg     <= outer_next;
            middle_reg    <= middle_next;
            inner_reg     <= inner_next;
            acc1_reg      <= acc1_next;
            acc2_reg      <= acc2_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.out_free    = !out_valid_reg || out_ready;
    assign out_valid          = out_valid_reg;
    assign out_source_address = out_src_reg;
    assign out_dest_address   = out_dst_reg;
    assign out_frame_last     = out_last_reg;
    assign out_config_error   = out_err_reg;

endmodule

FILE: rtl/pfa_index_permutation_top.sv
// An accepted request beat steps through N12, N123, T1, T2, SUM, SRC, DST and COMMIT,
// where the descriptor is registered once the output register is free. The single shared
// multiplier forms the factor product, both index terms and both scaled addresses in turn.
// The next request is taken once the previous descriptor sits in the output register.
// Reset (rst_n, asynchronous, active low) sets the registers to their defaults and the
// walk to the start of a frame; no clearing pass.
`include "pfa_index_permutation_top_macros.svh"

module pfa_index_permutation_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    pfa_req_if.sink                         req,
    pfa_desc_if.source                      desc
);

    pfa_pkg::cfg_t    cfg;
    pfa_pkg::cmd_t    cmd;
    pfa_pkg::status_t status;
    logic             req_ready;

    pfa_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pfa_datapath u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .cmd                (cmd),
        .status             (status),
        .in_restart         (req.restart),
        .out_ready          (desc.ready),
        .out_valid          (desc.valid),
        .out_source_address (desc.source_address),
        .out_dest_address   (desc.dest_address),
        .out_frame_last     (desc.frame_last),
        .out_config_error   (desc.config_error)
    );

    assign req.ready = req_ready;

    `PFA_ASSERT_IMP(a_error_beat_zero, desc.valid && desc.config_error, (desc.source_address == '0) && (desc.dest_address == '0) && !desc.frame_last, "error beat carries a non-zero payload")
    `PFA_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready, "request taken while a descriptor is in progress")
    `PFA_ASSERT_IMP(a_commit_free, cmd.commit, !desc.valid || desc.ready, "descriptor overwrites an unread beat")

endmodule

FILE: dv/pfa_index_permutation_top_tb.sv
module pfa_index_permutation_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic              last;
        logic              err;
    } desc_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pfa_req_if  req_bus ();
    pfa_desc_if desc_bus ();

    pfa_index_permutation_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_bus.sink),
        .desc      (desc_bus.source)
    );

    // register mirror
    map_mode_t           cfg_mode   = MODE_FWD2;
    logic [FACTOR_W-1:0] cfg_f1     = 1;
    logic [FACTOR_W-1:0] cfg_f2     = 1;
    logic [FACTOR_W-1:0] cfg_f3     = 1;
    logic [STEP_W-1:0]   cfg_s1     = '0;
    logic [STEP_W-1:0]   cfg_s2     = '0;
    logic [BASE_W-1:0]   cfg_base   = '0;
    logic [STRIDE_W-1:0] cfg_stride = 1;

    // walk state
    int unsigned walk_outer  = 0;
    int unsigned walk_middle = 0;
    int unsigned walk_inner  = 0;
    int unsigned acc_first   = 0;
    int unsigned acc_second  = 0;
    int unsigned walk_seq    = 0;

    logic        pending_restart[$];
    desc_t       expected_desc[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_desc = 1'b0;
    int unsigned mismatches = 0;
    int unsigned checked_beats = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit chance(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int unsigned wrap_once(int unsigned a, int unsigned m);
        return (a >= m) ? a - m : a;
    endfunction

    function automatic void clear_walk();
        walk_outer  = 0;
        walk_middle = 0;
        walk_inner  = 0;
        acc_first   = 0;
        acc_second  = 0;
        walk_seq    = 0;
    endfunction

    function automatic desc_t predict_descriptor(logic restart);
        logic            three;
        logic            ok;
        int unsigned     n1, n2, n3, mod_a, mod_b, lim_o, lim_m, lim_i, ka, kb;
        longint unsigned src_i, dst_i, addr;
        desc_t           d;
        d     = '0;
        three = cfg_mode[1];
        n1    = cfg_f1;
        n2    = cfg_f2;
        n3    = three ? int'(cfg_f3) : 1;
        if (restart)
            clear_walk();
        case (cfg_mode)
            MODE_FWD2:
            begin
                mod_a = n1; mod_b = 1; lim_o = n1; lim_m = 1; lim_i = n2;
            end
            MODE_BWD2:
            begin
                mod_a = n2; mod_b = 1; lim_o = n2; lim_m = 1; lim_i = n1;
            end
            MODE_FWD3:
            begin
                mod_a = n1; mod_b = n2; lim_o = n1; lim_m = n2; lim_i = n3;
            end
            default:
            begin
                mod_a = n2; mod_b = n3; lim_o = n3; lim_m = n2; lim_i = n1;
            end
        endcase
        ok = n1 >= 1 && n1 <= FACTOR_MAX && n2 >= 1 && n2 <= FACTOR_MAX
            && n3 >= 1 && n3 <= FACTOR_MAX;
        if (ok)
            ok = 64'(n1) * 64'(n2) * 64'(n3) <= 64'(MAX_POINTS);
        if (ok)
            ok = cfg_s1 < mod_a && (!three || cfg_s2 < mod_b);
        if (!ok)
        begin
            clear_walk();
            d.err = 1'b1;
            return d;
        end
        case (cfg_mode)
            MODE_FWD2:
            begin
                ka    = wrap_once(walk_outer + acc_first, n1);
                src_i = walk_seq;
                dst_i = ka + 64'(n1) * walk_inner;
            end
            MODE_BWD2:
            begin
                kb    = wrap_once(walk_outer + acc_first, n2);
                dst_i = walk_seq;
                src_i = walk_inner + 64'(n1) * kb;
            end
            MODE_FWD3:
            begin
                ka    = wrap_once(walk_outer + acc_first, n1);
                kb    = wrap_once(walk_middle + acc_second, n2);
                src_i = walk_seq;
                dst_i = ka + 64'(n1) * kb + 64'(n1) * 64'(n2) * walk_inner;
            end
            default:
            begin
                ka    = wrap_once(walk_middle + acc_first, n2);
                kb    = wrap_once(walk_outer + acc_second, n3);
                dst_i = walk_seq;
                src_i = walk_inner + 64'(n1) * ka + 64'(n1) * 64'(n2) * kb;
            end
        endcase
        acc_first  = wrap_once(acc_first + cfg_s1, mod_a);
        acc_second = three ? wrap_once(acc_second + cfg_s2, mod_b) : 0;
        walk_seq++;
        if (walk_inner + 1 >= lim_i)
        begin
            walk_inner = 0;
            if (cfg_mode == MODE_FWD3)
                acc_second = 0;
            if (cfg_mode == MODE_BWD3)
                acc_first = 0;
            if (walk_middle + 1 >= lim_m)
            begin
                walk_middle = 0;
                acc_first   = 0;
                acc_second  = 0;
                if (walk_outer + 1 >= lim_o)
                begin
                    walk_outer = 0;
                    walk_seq   = 0;
                    d.last     = 1'b1;
                end
                else
                    walk_outer++;
            end
            else
                walk_middle++;
        end
        else
            walk_inner++;
        addr       = 64'(cfg_base) + 64'(cfg_stride) * src_i;
        d.src_addr = addr[ADDR_W-1:0];
        addr       = 64'(cfg_base) + 64'(cfg_stride) * dst_i;
        d.dst_addr = addr[ADDR_W-1:0];
        return d;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: beat %0d: %s", $time, checked_beats, msg);
        mismatches++;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_bus.valid   <= 1'b0;
            req_bus.restart <= 1'b0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                expected_desc.push_back(predict_descriptor(req_bus.restart));
            if (!req_bus.valid || req_bus.ready)
            begin
                if (pending_restart.size() != 0 && !chance(send_idle_pct))
                begin
                    req_bus.valid   <= 1'b1;
                    req_bus.restart <= pending_restart.pop_front();
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // descriptor monitor
    always @(posedge clk)
    begin : desc_monitor
        desc_t want;
        if (!rst_n)
            desc_bus.ready <= 1'b0;
        else
        begin
            if (desc_bus.valid && desc_bus.ready)
            begin
                if (expected_desc.size() == 0)
                    report_mismatch($sformatf("descriptor with nothing expected: src %0h dst %0h",
                        desc_bus.source_address, desc_bus.dest_address));
                else
                begin
                    want = expected_desc.pop_front();
                    if (desc_bus.source_address !== want.src_addr)
                        report_mismatch($sformatf("source_address %0h, expected %0h",
                            desc_bus.source_address, want.src_addr));
                    if (desc_bus.dest_address !== want.dst_addr)
                        report_mismatch($sformatf("dest_address %0h, expected %0h",
                            desc_bus.dest_address, want.dst_addr));
                    if (desc_bus.frame_last !== want.last)
                        report_mismatch($sformatf("frame_last %b, expected %b",
                            desc_bus.frame_last, want.last));
                    if (desc_bus.config_error !== want.err)
                        report_mismatch($sformatf("config_error %b, expected %b",
                            desc_bus.config_error, want.err));
                end
                checked_beats++;
            end
            desc_bus.ready <= !hold_desc && !chance(recv_idle_pct);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_MAP_MODE:       cfg_mode   = map_mode_t'(val[MODE_W-1:0]);
            REG_FACTOR_ONE:     cfg_f1     = val[FACTOR_W-1:0];
            REG_FACTOR_TWO:     cfg_f2     = val[FACTOR_W-1:0];
            REG_FACTOR_THREE:   cfg_f3     = val[FACTOR_W-1:0];
            REG_STEP_FIRST:     cfg_s1     = val[STEP_W-1:0];
            REG_STEP_SECOND:    cfg_s2     = val[STEP_W-1:0];
            REG_BASE_ADDRESS:   cfg_base   = val[BASE_W-1:0];
            REG_ADDRESS_STRIDE: cfg_stride = val[STRIDE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(map_mode_t m, int unsigned f1, int unsigned f2, int unsigned f3,
                             int unsigned s1, int unsigned s2, int unsigned base,
                             int unsigned stride);
        write_reg(REG_MAP_MODE, m);
        write_reg(REG_FACTOR_ONE, f1);
        write_reg(REG_FACTOR_TWO, f2);
        write_reg(REG_FACTOR_THREE, f3);
        write_reg(REG_STEP_FIRST, s1);
        write_reg(REG_STEP_SECOND, s2);
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_ADDRESS_STRIDE, stride);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_restart.size() != 0 || req_bus.valid || expected_desc.size() != 0);
    endtask

    initial
    begin
        int unsigned send_tab[4];
        int unsigned recv_tab[4];
        int unsigned items_sent;
        int unsigned phase_no;
        int unsigned kind, f1, f2, f3, s1, s2, ma, mb, n, frame, stride;
        map_mode_t   m;
        logic        three;

        send_tab = '{0, 48, 0, 21};
        recv_tab = '{0, 0, 48, 21};
        req_bus.valid   = 1'b0;
        req_bus.restart = 1'b0;
        desc_bus.ready  = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_MAP_MODE;
        cfg_data        = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: single-element frames
        pending_restart = '{1'b0, 1'b1};
        drain();

        // top of the base address range and a full frame
        configure(MODE_FWD2, 3, 2, 1, 2, 0, 24'hFFFFFF, 4096);
        pending_restart = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        drain();

        // part of a frame, then a new mode carried on from the same counters
        configure(MODE_BWD2, 2, 3, 1, 1, 0, 24'h000100, 3);
        pending_restart = '{1'b1, 1'b0, 1'b0, 1'b0};
        drain();
        configure(MODE_FWD3, 2, 3, 2, 1, 2, 24'h800000, 5);
        pending_restart = '{1'b0, 1'b0, 1'b0, 1'b0};
        drain();

        configure(MODE_BWD3, 2, 2, 3, 1, 2, 24'h123456, 7);
        pending_restart = '{1'b1, 1'b0, 1'b0};
        drain();

        // bad settings: zero factor, oversized factor, product, unreduced steps
        configure(MODE_FWD2, 0, 2, 1, 0, 0, 24'h000010, 1);
        pending_restart = '{1'b0};
        drain();
        configure(MODE_FWD2, 5000, 2, 1, 0, 0, 24'h000010, 1);
        pending_restart = '{1'b0};
        drain();
        configure(MODE_FWD3, 64, 64, 2, 0, 0, 24'h000010, 1);
        pending_restart = '{1'b0};
        drain();
        configure(MODE_FWD2, 3, 2, 1, 3, 0, 24'h000010, 1);
        pending_restart = '{1'b0};
        drain();
        configure(MODE_BWD3, 1, 2, 3, 1, 3, 24'h000010, 1);
        pending_restart = '{1'b0};
        drain();
        items_sent = 24;

        phase_no = 0;
        while (items_sent < 1300)
        begin
            send_idle_pct = send_tab[phase_no % 4];
            recv_idle_pct = recv_tab[phase_no % 4];
            m     = map_mode_t'($urandom_range(3));
            three = m[1];
            kind  = $urandom_range(99);
            if (kind < 6)
            begin
                f1 = 1;
                f2 = 1;
                f3 = 1;
                case ($urandom_range(2))
                    0:       f1 = 4096;
                    1:       f2 = 4096;
                    default: f3 = 4096;
                endcase
            end
            else
            begin
                f1 = $urandom_range(7, 1);
                f2 = $urandom_range(7, 1);
                f3 = (!three && chance(30)) ? $urandom_range(8191) : $urandom_range(5, 1);
            end
            case (m)
                MODE_FWD2: begin ma = f1; mb = 1; end
                MODE_BWD2: begin ma = f2; mb = 1; end
                MODE_FWD3: begin ma = f1; mb = f2; end
                default:   begin ma = f2; mb = f3; end
            endcase
            s1 = $urandom_range(ma - 1);
            s2 = three ? $urandom_range(mb - 1) : $urandom_range(4095);
            frame = f1 * f2 * (three ? f3 : 1);
            if (kind >= 6 && kind < 16)
            begin
                case ($urandom_range(4))
                    0:
                    begin
                        f1 = chance(50) ? 0 : f1;
                        f2 = (f1 != 0) ? 0 : f2;
                    end
                    1:       f2 = $urandom_range(8191, 4097);
                    2:
                    begin
                        f1 = $urandom_range(4096, 65);
                        f2 = $urandom_range(4096, 65);
                    end
                    3:       s1 = $urandom_range(4095, ma);
                    default:
                    begin
                        if (three)
                            s2 = $urandom_range(4095, mb);
                        else
                            s1 = $urandom_range(4095, ma);
                    end
                endcase
                n = $urandom_range(6, 2);
            end
            else
            begin
                n = frame * $urandom_range(2, 1) + $urandom_range(3);
                n = (n < 4) ? 4 : (n > 60) ? 60 : n;
            end
            stride = chance(10) ? $urandom_range(8191) : $urandom_range(4096, 1);
            configure(m, f1, f2, f3, s1, s2, $urandom_range(24'hFFFFFF), stride);
            if (phase_no == 2)
            begin
                n = (n < 40) ? 40 : n;
                fork
                    begin
                        hold_desc <= 1'b1;
                        repeat (300) @(posedge clk);
                        hold_desc <= 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < n; i++)
                pending_restart.push_back(i == 0 ? chance(70) : chance(3));
            items_sent += n;
            drain();
            phase_no++;
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS pfa_index_permutation_top");
        else
            $display("FAIL pfa_index_permutation_top");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL pfa_index_permutation_top");
        $finish;
    end

endmodule
